>>> rtl/rpn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared constants, control-word layout and helpers for the RPN evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int UPC_W       = 5;

    // characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_UND  = 2'd2;
    localparam logic [1:0] ST_DIV0 = 2'd3;

    // datapath actions
    localparam logic [3:0] A_NOP      = 4'd0;
    localparam logic [3:0] A_FETCH    = 4'd1;
    localparam logic [3:0] A_EMIT     = 4'd2;
    localparam logic [3:0] A_LD_DIGIT = 4'd3;
    localparam logic [3:0] A_ERR_OVF  = 4'd4;
    localparam logic [3:0] A_LD_B     = 4'd5;
    localparam logic [3:0] A_LD_A_POP = 4'd6;
    localparam logic [3:0] A_ALU      = 4'd7;
    localparam logic [3:0] A_DIV_GO   = 4'd8;
    localparam logic [3:0] A_LD_QUO   = 4'd9;
    localparam logic [3:0] A_ERR_UND  = 4'd10;
    localparam logic [3:0] A_PUSH     = 4'd11;
    localparam logic [3:0] A_FIN_CLR  = 4'd12;
    localparam logic [3:0] A_ERR_DIV  = 4'd13;

    // jump conditions
    localparam logic [3:0] C_NEXT      = 4'd0;
    localparam logic [3:0] C_ALWAYS    = 4'd1;
    localparam logic [3:0] C_NO_XFER   = 4'd2;
    localparam logic [3:0] C_FIN       = 4'd3;
    localparam logic [3:0] C_ERR_OR_EQ = 4'd4;
    localparam logic [3:0] C_DIGIT     = 4'd5;
    localparam logic [3:0] C_OPER      = 4'd6;
    localparam logic [3:0] C_NOT_END   = 4'd7;
    localparam logic [3:0] C_FULL      = 4'd8;
    localparam logic [3:0] C_LT2       = 4'd9;
    localparam logic [3:0] C_DIVOP     = 4'd10;
    localparam logic [3:0] C_BZERO     = 4'd11;
    localparam logic [3:0] C_DIV_BUSY  = 4'd12;
    localparam logic [3:0] C_OUT_BUSY  = 4'd13;

    typedef struct packed {
        logic [3:0]       act;
        logic [3:0]       cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic no_xfer;
        logic fin;
        logic err_or_eq;
        logic digit;
        logic oper;
        logic not_end;
        logic full;
        logic lt2;
        logic divop;
        logic bzero;
        logic div_busy;
        logic out_busy;
    } t_flags;

    // sign-extend a stack value and keep its low 32 bits
    function automatic logic [31:0] to_out32(input logic signed [VALUE_WIDTH-1:0] d);
        logic signed [63:0] e;
        e = 64'(d);
        return e[31:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/rpn_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/rpn_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_div
// Signed divider, one restoring step per cycle, quotient truncated to zero.
// ----------------------------------------------------------------------------
module rpn_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [rpn_pkg::VALUE_WIDTH-1:0] i_a,
    input  wire logic [rpn_pkg::VALUE_WIDTH-1:0] i_b,
    output logic                                o_busy,
    output logic      [rpn_pkg::VALUE_WIDTH-1:0] o_quo
);
    import rpn_pkg::*;

    localparam int DC_W = $clog2(VALUE_WIDTH) + 1;

    logic                   r_busy;
    logic [DC_W-1:0]        r_cnt;
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_dvs;
    logic [VALUE_WIDTH:0]   trial;
    logic                   fits;

    assign trial = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DC_W'(VALUE_WIDTH);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DC_W'(1);
            if (r_cnt == DC_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_a[VALUE_WIDTH-1] ^ i_b[VALUE_WIDTH-1];
            r_quo <= i_a[VALUE_WIDTH-1] ? (~i_a + 1'b1) : i_a;
            r_dvs <= i_b[VALUE_WIDTH-1] ? (~i_b + 1'b1) : i_b;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? VALUE_WIDTH'(trial - {1'b0, r_dvs}) : trial[VALUE_WIDTH-1:0];
            r_quo <= {r_quo[VALUE_WIDTH-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule
`default_nettype wire

>>> rtl/rpn_useq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_useq
// Microprogram ROM and step counter; branches on datapath flags.
// ----------------------------------------------------------------------------
module rpn_useq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rpn_pkg::t_flags i_flags,
    output rpn_pkg::t_uword      o_uword
);
    import rpn_pkg::*;

    localparam logic [UPC_W-1:0] L_FETCH  = UPC_W'(0);
    localparam logic [UPC_W-1:0] L_ENDCHK = UPC_W'(8);
    localparam logic [UPC_W-1:0] L_EMIT   = UPC_W'(9);
    localparam logic [UPC_W-1:0] L_ERROVF = UPC_W'(13);
    localparam logic [UPC_W-1:0] L_OPER   = UPC_W'(14);
    localparam logic [UPC_W-1:0] L_DIGIT  = UPC_W'(11);
    localparam logic [UPC_W-1:0] L_DIV    = UPC_W'(19);
    localparam logic [UPC_W-1:0] L_DWAIT  = UPC_W'(21);
    localparam logic [UPC_W-1:0] L_ERRUND = UPC_W'(23);
    localparam logic [UPC_W-1:0] L_PUSH   = UPC_W'(24);
    localparam logic [UPC_W-1:0] L_FINCLR = UPC_W'(25);
    localparam logic [UPC_W-1:0] L_ERRDIV = UPC_W'(26);

    function automatic t_uword rom(input logic [UPC_W-1:0] a);
        t_uword w;
        w = '{A_NOP, C_ALWAYS, L_FETCH};
        case (a)
            5'd0:  w = '{A_FETCH,    C_NO_XFER,   L_FETCH};
            5'd1:  w = '{A_NOP,      C_FIN,       L_FINCLR};
            5'd2:  w = '{A_NOP,      C_ERR_OR_EQ, L_ENDCHK};
            5'd3:  w = '{A_NOP,      C_DIGIT,     L_DIGIT};
            5'd4:  w = '{A_NOP,      C_OPER,      L_OPER};
            5'd5:  w = '{A_NOP,      C_ALWAYS,    L_ENDCHK};
            5'd8:  w = '{A_NOP,      C_NOT_END,   L_FETCH};
            5'd9:  w = '{A_EMIT,     C_OUT_BUSY,  L_EMIT};
            5'd10: w = '{A_NOP,      C_ALWAYS,    L_FETCH};
            5'd11: w = '{A_NOP,      C_FULL,      L_ERROVF};
            5'd12: w = '{A_LD_DIGIT, C_ALWAYS,    L_PUSH};
            5'd13: w = '{A_ERR_OVF,  C_ALWAYS,    L_ENDCHK};
            5'd14: w = '{A_NOP,      C_LT2,       L_ERRUND};
            5'd15: w = '{A_NOP,      C_NEXT,      L_FETCH};
            5'd16: w = '{A_LD_B,     C_NEXT,      L_FETCH};
            5'd17: w = '{A_LD_A_POP, C_DIVOP,     L_DIV};
            5'd18: w = '{A_ALU,      C_ALWAYS,    L_PUSH};
            5'd19: w = '{A_NOP,      C_BZERO,     L_ERRDIV};
            5'd20: w = '{A_DIV_GO,   C_NEXT,      L_FETCH};
            5'd21: w = '{A_NOP,      C_DIV_BUSY,  L_DWAIT};
            5'd22: w = '{A_LD_QUO,   C_ALWAYS,    L_PUSH};
            5'd23: w = '{A_ERR_UND,  C_ALWAYS,    L_ENDCHK};
            5'd24: w = '{A_PUSH,     C_ALWAYS,    L_ENDCHK};
            5'd25: w = '{A_FIN_CLR,  C_ALWAYS,    L_FETCH};
            5'd26: w = '{A_ERR_DIV,  C_ALWAYS,    L_ENDCHK};
            default: w = '{A_NOP,    C_ALWAYS,    L_FETCH};
        endcase
        return w;
    endfunction

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           uw;
    logic             take;

    assign uw = rom(r_upc);

    always_comb begin
        case (uw.cond)
            C_NEXT:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_XFER:   take = i_flags.no_xfer;
            C_FIN:       take = i_flags.fin;
            C_ERR_OR_EQ: take = i_flags.err_or_eq;
            C_DIGIT:     take = i_flags.digit;
            C_OPER:      take = i_flags.oper;
            C_NOT_END:   take = i_flags.not_end;
            C_FULL:      take = i_flags.full;
            C_LT2:       take = i_flags.lt2;
            C_DIVOP:     take = i_flags.divop;
            C_BZERO:     take = i_flags.bzero;
            C_DIV_BUSY:  take = i_flags.div_busy;
            C_OUT_BUSY:  take = i_flags.out_busy;
            default:     take = 1'b1;
        endcase
        n_upc = take ? uw.target : r_upc + UPC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= L_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_uword = uw;

endmodule
`default_nettype wire

>>> rtl/rpn_digit_stack_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_digit_stack_evaluator
// RPN evaluator: microcoded control over a stack RAM, ALU and divider.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one ASCII character per transfer; tlast marks the final
//   character of an expression. Digits push 0..9, + - * / pop two values and
//   push the result (second popped is the left operand, wrapping arithmetic,
//   division truncates toward zero). At '=' or at tlast the top value goes
//   out on m_axis: tdata = value, tuser = status (0 ok, 1 overflow,
//   2 underflow, 3 divide by zero); the stack and status then clear.
//   Characters after '=' are dropped up to tlast.
// Timing:
//   One character at a time: a new character is taken only once the last one
//   is done, and a / also waits for the bit-per-cycle divider to finish.
// Reset (synchronous, active low) empties the stack and clears the status.
// If m_axis stalls, the result waits in the output register; the next
// expression keeps running and only stalls at its own result.
// ----------------------------------------------------------------------------
module rpn_digit_stack_evaluator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [31:0] value
    output logic      [1:0]  m_axis_tuser    // [1:0] status
);
    import rpn_pkg::*;

    t_uword uw;
    t_flags flags;

    logic [7:0]             r_char;
    logic                   r_last;
    logic [CNT_W-1:0]       r_count;
    logic [1:0]             r_err;
    logic                   r_fin;
    logic [VALUE_WIDTH-1:0] r_a;
    logic [VALUE_WIDTH-1:0] r_b;
    logic [VALUE_WIDTH-1:0] r_acc;
    logic                   r_ovalid;
    logic [31:0]            r_oval;
    logic [1:0]             r_ostat;

    logic                   is_eq;
    logic                   out_busy;
    logic                   do_emit;
    logic [IDX_W-1:0]       rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic                   div_busy;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [1:0]             emit_st;
    logic [VALUE_WIDTH-1:0] alu_res;

    rpn_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw)
    );

    // top of stack by default; the left operand while loading B
    assign rd_addr = (uw.act == A_LD_B) ? IDX_W'(r_count - CNT_W'(2))
                                        : IDX_W'(r_count - CNT_W'(1));

    rpn_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (uw.act == A_PUSH),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_acc),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    rpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (uw.act == A_DIV_GO),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    assign is_eq    = (r_char == CH_EQ);
    assign out_busy = r_ovalid && !m_axis_tready;
    assign do_emit  = (uw.act == A_EMIT) && !out_busy;

    always_comb begin
        flags.no_xfer   = !s_axis_tvalid;
        flags.fin       = r_fin;
        flags.err_or_eq = (r_err != ST_OK) || is_eq;
        flags.digit     = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
        flags.oper      = (r_char == CH_PLUS) || (r_char == CH_MINUS) ||
                          (r_char == CH_MUL) || (r_char == CH_DIV);
        flags.not_end   = !(is_eq || r_last);
        flags.full      = (r_count == CNT_W'(STACK_DEPTH));
        flags.lt2       = (r_count < CNT_W'(2));
        flags.divop     = (r_char == CH_DIV);
        flags.bzero     = (r_b == '0);
        flags.div_busy  = div_busy;
        flags.out_busy  = out_busy;
    end

    always_comb begin
        case (r_char)
            CH_PLUS:  alu_res = r_a + r_b;
            CH_MINUS: alu_res = r_a - r_b;
            default:  alu_res = VALUE_WIDTH'(r_a * r_b);
        endcase
    end

    always_comb begin
        if (r_err != ST_OK) begin
            emit_st = r_err;
        end else if (r_count == '0) begin
            emit_st = ST_UND;
        end else begin
            emit_st = ST_OK;
        end
    end

    assign s_axis_tready = (uw.act == A_FETCH);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_err    <= ST_OK;
            r_fin    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            case (uw.act)
                A_ERR_OVF:  r_err <= ST_OVF;
                A_ERR_UND:  r_err <= ST_UND;
                A_ERR_DIV:  r_err <= ST_DIV0;
                A_LD_A_POP: r_count <= r_count - CNT_W'(2);
                A_PUSH:     r_count <= r_count + CNT_W'(1);
                A_FIN_CLR:  r_fin <= r_fin && !r_last;
                default: begin
                end
            endcase
            if (do_emit) begin
                r_count <= '0;
                r_err   <= ST_OK;
                r_fin   <= is_eq && !r_last;
            end
            if (do_emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_char <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
        case (uw.act)
            A_LD_DIGIT: r_acc <= VALUE_WIDTH'(r_char[3:0]);
            A_ALU:      r_acc <= alu_res;
            A_LD_QUO:   r_acc <= div_quo;
            A_LD_B:     r_b   <= rd_data;
            A_LD_A_POP: r_a   <= rd_data;
            default: begin
            end
        endcase
        if (do_emit) begin
            r_ostat <= emit_st;
            r_oval  <= (emit_st == ST_OK) ? to_out32(rd_data) : 32'd0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_oval;
    assign m_axis_tuser  = r_ostat;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_err_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == 32'd0))
        else $error("error result with nonzero value");

    a_fin_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> (r_err == ST_OK))
        else $error("error pending while skipping to end of frame");

    a_div_only_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> !s_axis_tready)
        else $error("input taken while divider busy");

endmodule
`default_nettype wire

>>> verif/rpn_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_checker
// Watches both stream channels of the RPN evaluator, runs its own model of the
// operand stack on every accepted character and compares each result transfer
// with the oldest predicted result, field by field.
// ----------------------------------------------------------------------------
module rpn_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  m_axis_tuser,   // [1:0] status
    output int               o_fail_count,
    output int               o_results_due
);
    import rpn_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } t_expr_result;

    logic [VALUE_WIDTH-1:0] operand_mem [STACK_DEPTH];
    int unsigned            depth;
    logic [1:0]             expr_status;
    bit                     skip_to_end;   // '=' seen, dropping chars up to tlast
    t_expr_result           result_q[$];
    int                     fail_total = 0;
    int                     due_count  = 0;

    assign o_fail_count  = fail_total;
    assign o_results_due = due_count;

    task automatic report_mismatch(input string what);
        if (fail_total < 100) $display("[%0t] mismatch: %s", $time, what);
        fail_total++;
    endtask

    // Advance the stack model by one character; flags a result when the
    // expression closes.
    task automatic eval_char(input logic [7:0] ch, input logic last,
                             output bit emits, output t_expr_result res);
        logic [VALUE_WIDTH-1:0] lhs, rhs, mag_l, mag_r, alu, top_val;
        bit                     do_push;
        emits = 1'b0;
        res   = '0;
        if (skip_to_end) begin
            if (last) skip_to_end = 1'b0;
        end else begin
            if (ch != CH_EQ && expr_status == ST_OK) begin
                if (ch >= CH_ZERO && ch <= CH_NINE) begin
                    if (depth >= STACK_DEPTH) begin
                        expr_status = ST_OVF;
                    end else begin
                        operand_mem[depth] = VALUE_WIDTH'(ch - CH_ZERO);
                        depth++;
                    end
                end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_MUL ||
                             ch == CH_DIV) begin
                    if (depth < 2) begin
                        expr_status = ST_UND;
                    end else begin
                        rhs     = operand_mem[depth-1];
                        lhs     = operand_mem[depth-2];
                        depth   = depth - 2;
                        do_push = 1'b1;
                        alu     = '0;
                        case (ch)
                            CH_PLUS:  alu = lhs + rhs;
                            CH_MINUS: alu = lhs - rhs;
                            CH_MUL:   alu = lhs * rhs;
                            default: begin
                                if (rhs == '0) begin
                                    // both operands stay popped
                                    expr_status = ST_DIV0;
                                    do_push     = 1'b0;
                                end else begin
                                    // truncate toward zero on magnitudes
                                    mag_l = lhs[VALUE_WIDTH-1] ? -lhs : lhs;
                                    mag_r = rhs[VALUE_WIDTH-1] ? -rhs : rhs;
                                    alu   = mag_l / mag_r;
                                    if (lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1]) alu = -alu;
                                end
                            end
                        endcase
                        if (do_push) begin
                            operand_mem[depth] = alu;
                            depth++;
                        end
                    end
                end
            end
            if (ch == CH_EQ || last) begin
                res.status = expr_status;
                if (expr_status == ST_OK) begin
                    if (depth == 0) begin
                        res.status = ST_UND;
                    end else begin
                        top_val   = operand_mem[depth-1];
                        res.value = 32'({{(64-VALUE_WIDTH){top_val[VALUE_WIDTH-1]}}, top_val});
                    end
                end
                emits       = 1'b1;
                depth       = 0;
                expr_status = ST_OK;
                skip_to_end = (ch == CH_EQ) && !last;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        bit           emits;
        t_expr_result got_pred;
        t_expr_result want;
        if (!i_rst_n) begin
            depth       = 0;
            expr_status = ST_OK;
            skip_to_end = 1'b0;
            result_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (result_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d status %0d",
                                              $signed(m_axis_tdata), m_axis_tuser));
                end else begin
                    want = result_q.pop_front();
                    if (m_axis_tdata !== want.value)
                        report_mismatch($sformatf("value got %0d want %0d",
                                                  $signed(m_axis_tdata), $signed(want.value)));
                    if (m_axis_tuser !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  m_axis_tuser, want.status));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                eval_char(s_axis_tdata, s_axis_tlast, emits, got_pred);
                if (emits) result_q.push_back(got_pred);
            end
        end
        due_count = result_q.size();
    end

endmodule
`default_nettype wire

>>> verif/tb_rpn_digit_stack_evaluator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_rpn_digit_stack_evaluator
// Feeds RPN expressions character by character: a short directed set for the
// corner cases, then random well-formed, wrapping, overflowing, broken and
// noise expressions, with random stalls on both channels. rpn_checker does
// the prediction and comparison; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_rpn_digit_stack_evaluator;
    import rpn_pkg::*;

    localparam int CHAR_GOAL = 500;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char_xfer;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] char_code
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] value
    logic [1:0]  m_axis_tuser;         // [1:0] status

    int          fail_count;
    int          results_due;
    int          chars_sent = 0;
    bit          steady     = 1'b0;    // no stalls on either side
    bit          tail_calm  = 1'b0;
    t_char_xfer  expr_q[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rpn_digit_stack_evaluator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rpn_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    task automatic send_char(input logic [7:0] code, input logic last);
        int gap;
        steady = tail_calm || ((chars_sent / 80) % 4 == 3);
        if (!steady && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic add_char(input logic [7:0] code, input logic last = 1'b0);
        t_char_xfer c;
        c.code = code;
        c.last = last;
        expr_q.push_back(c);
    endtask

    task automatic add_digit(input int d);
        add_char(CH_ZERO + 8'(d));
    endtask

    task automatic send_expr();
        foreach (expr_q[i]) send_char(expr_q[i].code, expr_q[i].last);
        expr_q.delete();
    endtask

    function automatic logic [7:0] random_op();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    function automatic logic [7:0] filler_char();
        logic [7:0] c;
        c = 8'($urandom);
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_EQ || c == CH_PLUS ||
               c == CH_MINUS || c == CH_MUL || c == CH_DIV)
            c = 8'($urandom);
        return c;
    endfunction

    // End an expression: tlast on its own final char, '=' with tlast, or '='
    // followed by chars that must be dropped up to tlast.
    task automatic close_expr();
        int n;
        case ($urandom_range(0, 3))
            0: begin
                if (expr_q.size() == 0) add_char(8'($urandom), 1'b1);
                else expr_q[expr_q.size()-1].last = 1'b1;
            end
            1: add_char(CH_EQ, 1'b1);
            default: begin
                add_char(CH_EQ);
                n = $urandom_range(0, 3);
                repeat (n) add_char(8'($urandom));
                add_char(8'($urandom), 1'b1);
            end
        endcase
        send_expr();
    endtask

    task automatic gen_formed();
        int left, live, keep;
        left = $urandom_range(1, 9);
        live = 0;
        keep = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 3) : 1;
        while (left > 0 || live > keep) begin
            if ($urandom_range(0, 9) == 0) add_char(filler_char());
            if (left > 0 && (live < 2 || $urandom_range(0, 1) == 1)) begin
                add_digit($urandom_range(0, 9));
                left--;
                live++;
            end else begin
                add_char(random_op());
                live--;
            end
        end
        close_expr();
    endtask

    // Large and wrapping values, including the most negative value against -1.
    task automatic gen_wide();
        int n;
        if ($urandom_range(0, 1) == 0) begin
            add_digit(8);
            repeat (9) begin
                add_digit(8);
                add_char(CH_MUL);
            end
            add_digit(2);
            add_char(CH_MUL);
            if ($urandom_range(0, 1) == 0) begin
                add_digit(0);
                add_digit(1);
                add_char(CH_MINUS);
                add_char(random_op());
            end
        end else begin
            add_digit($urandom_range(2, 9));
            n = $urandom_range(5, 14);
            repeat (n) begin
                add_digit($urandom_range(2, 9));
                add_char(CH_MUL);
            end
        end
        n = $urandom_range(0, 3);
        repeat (n) begin
            add_digit($urandom_range(0, 9));
            add_char(random_op());
        end
        close_expr();
    endtask

    // Fills the stack to the brim, sometimes one or two past it.
    task automatic gen_overflow();
        int n;
        n = STACK_DEPTH + $urandom_range(0, 2);
        repeat (n) add_digit($urandom_range(0, 9));
        n = $urandom_range(0, 2);
        repeat (n) add_char(random_op());
        close_expr();
    endtask

    task automatic gen_broken();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            if ($urandom_range(0, 1) == 0) add_char(random_op());
            else add_digit($urandom_range(0, 9));
        end
        close_expr();
    endtask

    task automatic gen_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) send_char(8'($urandom), ($urandom_range(0, 3) == 0));
    endtask

    initial begin : sink_pacing
        int n;
        forever begin
            @(posedge i_clk);
            if (!steady && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 7);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial begin : stimulus
        int pick;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty stack at '='
        add_char(CH_EQ, 1'b1);
        send_expr();
        // add, closed by tlast on the operator
        add_digit(3);
        add_digit(4);
        add_char(CH_PLUS, 1'b1);
        send_expr();
        // subtract and negative quotient truncated toward zero
        add_digit(0);
        add_digit(7);
        add_char(CH_MINUS);
        add_digit(2);
        add_char(CH_DIV);
        add_char(CH_EQ, 1'b1);
        send_expr();
        // divide by zero
        add_digit(5);
        add_digit(0);
        add_char(CH_DIV);
        add_char(CH_EQ, 1'b1);
        send_expr();
        // operator on an empty stack
        add_char(CH_PLUS, 1'b1);
        send_expr();
        // multiply, '=' without tlast, then dropped chars up to tlast
        add_digit(7);
        add_digit(8);
        add_char(CH_MUL);
        add_char(CH_EQ);
        add_char(8'hFF);
        add_char(8'h00, 1'b1);
        send_expr();
        // ignored char marked last on an empty stack
        add_char(8'hFF, 1'b1);
        send_expr();
        // extra entries left: only the top one counts
        add_digit(1);
        add_digit(2);
        add_char(CH_EQ, 1'b1);
        send_expr();

        gen_overflow();
        while (chars_sent < CHAR_GOAL) begin
            if (chars_sent >= CHAR_GOAL - 80) tail_calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 55)      gen_formed();
            else if (pick < 67) gen_wide();
            else if (pick < 70) gen_overflow();
            else if (pick < 88) gen_broken();
            else                gen_noise();
        end

        tail_calm = 1'b1;
        steady    = 1'b1;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : run_limit
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
rtl/rpn_pkg.sv
rtl/rpn_ram.sv
rtl/rpn_div.sv
rtl/rpn_useq.sv
rtl/rpn_digit_stack_evaluator.sv
verif/rpn_checker.sv
verif/tb_rpn_digit_stack_evaluator.sv
